// ===== src/cdq_pkg.sv =====
package cdq_pkg;

   // fixed field widths
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 4;
   localparam int FILL_W = 4;
   localparam int CMD_W = 2;
   localparam int STATUS_W = 2;

   // most words one pop may give
   localparam int MAX_RESULTS = 8;

   // default store depth
   localparam int DEF_CAPACITY = 8;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUSH_REAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd2;
   localparam logic [CMD_W-1:0] CMD_POP_REAR = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic                capture;
      logic                push_en;
      logic                read_en;
      logic                load_out;
      logic                out_use_data;
      logic [STATUS_W-1:0] out_status;
      logic                out_last;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic               is_push;
      logic               full;
      logic               empty;
      logic               count_zero;
      logic [COUNT_W-1:0] take;
      logic               out_free;
   } dp_status_type;

endpackage

// ===== src/cdq_datapath.sv =====
module cdq_datapath #(
   parameter int CAPACITY = cdq_pkg::DEF_CAPACITY
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cdq_pkg::dp_cmd_type          cmd,
   output cdq_pkg::dp_status_type       status,
   input  logic [cdq_pkg::CMD_W-1:0]    in_command,
   input  logic [cdq_pkg::VALUE_W-1:0]  in_value,
   input  logic [cdq_pkg::COUNT_W-1:0]  in_count,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [cdq_pkg::VALUE_W-1:0]  out_value,
   output logic [cdq_pkg::STATUS_W-1:0] out_status,
   output logic                         out_last,
   output logic [cdq_pkg::FILL_W-1:0]   out_fill
);
   import cdq_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int OCC_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = OCC_W + COUNT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
   localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(CAPACITY);

   // entry store
   logic [VALUE_W-1:0] mem [CAPACITY];
   logic [VALUE_W-1:0] rd_data_ff;

   // pointers and count
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [OCC_W-1:0] occ_ff, occ_in;

   // captured command word
   logic [CMD_W-1:0]   cmd_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [COUNT_W-1:0] count_ff;

   // output register
   logic                valid_ff, valid_in;
   logic [VALUE_W-1:0]  value_out_ff;
   logic [STATUS_W-1:0] status_out_ff;
   logic                last_out_ff;
   logic [FILL_W-1:0]   fill_out_ff;

   logic               is_push;
   logic               is_front;
   logic [IDX_W-1:0]   wr_addr;
   logic [IDX_W-1:0]   rd_addr;
   logic [COUNT_W-1:0] sat_count;
   logic [CMP_W-1:0]   sat_wide;
   logic [CMP_W-1:0]   occ_wide;
   logic [CMP_W-1:0]   take_wide;
   logic [CMP_W-1:0]   fill_wide;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
      return (i == '0) ? LAST_IDX : i - 1'b1;
   endfunction

   // decode of the held command
   assign is_push = (cmd_ff == CMD_PUSH_REAR) || (cmd_ff == CMD_PUSH_FRONT);
   assign is_front = (cmd_ff == CMD_PUSH_FRONT) || (cmd_ff == CMD_POP_FRONT);

   // run length: request saturated, then limited by what is stored
   assign sat_count = (count_ff > COUNT_W'(MAX_RESULTS)) ? COUNT_W'(MAX_RESULTS) : count_ff;
   assign sat_wide = {{OCC_W{1'b0}}, sat_count};
   assign occ_wide = {{COUNT_W{1'b0}}, occ_ff};
   assign take_wide = (sat_wide < occ_wide) ? sat_wide : occ_wide;

   // pointer and count updates
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      occ_in = occ_ff;
      if (cmd.push_en) begin
         if (is_front) begin
            head_in = wrap_dec(head_ff);
         end else begin
            tail_in = wrap_inc(tail_ff);
         end
         occ_in = occ_ff + 1'b1;
      end else if (cmd.read_en) begin
         if (is_front) begin
            head_in = wrap_inc(head_ff);
         end else begin
            tail_in = wrap_dec(tail_ff);
         end
         occ_in = occ_ff - 1'b1;
      end
   end

   assign wr_addr = is_front ? head_in : tail_in;
   assign rd_addr = is_front ? head_ff : tail_ff;

   // fill level after this word, modulo the field width
   assign fill_wide = {{COUNT_W{1'b0}}, occ_in};

   // output slot handshake
   assign valid_in = cmd.load_out | (valid_ff & ~out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= LAST_IDX;
         occ_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff <= occ_in;
         valid_ff <= valid_in;
      end
   end

   // store write and registered read
   always_ff @(posedge clock) begin
      if (cmd.push_en) begin
         mem[wr_addr] <= value_ff;
      end
      if (cmd.read_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // command capture and output payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= in_command;
         value_ff <= in_value;
         count_ff <= in_count;
      end
      if (cmd.load_out) begin
         value_out_ff <= cmd.out_use_data ? rd_data_ff : '0;
         status_out_ff <= cmd.out_status;
         last_out_ff <= cmd.out_last;
         fill_out_ff <= fill_wide[FILL_W-1:0];
      end
   end

   assign status.is_push = is_push;
   assign status.full = (occ_ff == FULL_OCC);
   assign status.empty = (occ_ff == '0);
   assign status.count_zero = (count_ff == '0);
   assign status.take = take_wide[COUNT_W-1:0];
   assign status.out_free = ~valid_ff | out_ready;

   assign out_valid = valid_ff;
   assign out_value = value_out_ff;
   assign out_status = status_out_ff;
   assign out_last = last_out_ff;
   assign out_fill = fill_out_ff;

endmodule

// ===== src/cdq_ctrl.sv =====
module cdq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  cdq_pkg::dp_status_type status,
   output cdq_pkg::dp_cmd_type    cmd
);
   import cdq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_START,
      S_READ,
      S_DATA
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] remain_ff, remain_in;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      remain_in = remain_ff;
      cmd = '0;
      cmd.out_status = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.capture = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            priority if (status.is_push) begin
               if (status.out_free) begin
                  cmd.push_en = ~status.full;
                  cmd.load_out = 1'b1;
                  cmd.out_status = status.full ? ST_FULL : ST_OK;
                  cmd.out_last = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (status.empty || status.count_zero) begin
               if (status.out_free) begin
                  cmd.load_out = 1'b1;
                  cmd.out_status = status.empty ? ST_EMPTY : ST_OK;
                  cmd.out_last = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               remain_in = status.take;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.read_en = 1'b1;
            remain_in = remain_ff - 1'b1;
            state_in = S_DATA;
         end
         S_DATA: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_use_data = 1'b1;
               cmd.out_last = (remain_ff == '0);
               state_in = (remain_ff == '0) ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and run counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         remain_ff <= '0;
      end else begin
         state_ff <= state_in;
         remain_ff <= remain_in;
      end
   end

   assign in_ready = (state_ff == S_IDLE);

endmodule

// ===== src/circular_deque.sv =====
// Double-ended queue of CAPACITY signed 32-bit values in a circular store.
// Each request word pushes one value at the rear or front, or pops up to
// pop_count values (saturated at eight) from the front or rear. A push gives
// one response word with status ok or full; a pop gives one word per value
// removed, in removal order, with tlast on the final one, or a single word
// with status empty when nothing is stored. A pop count of zero on a non-empty
// deque gives one ok word and changes nothing. Every response carries the fill
// level after it, modulo 16. A request is taken in the idle state once the
// previous one finishes. A push, or a pop that removes nothing, loads its
// response in the start state; other pops take a read and a data state per
// value for the registered store read. The response register lets a request be
// taken while the last response still waits, and stalls the run when full.
module circular_deque #(
   parameter int CAPACITY = cdq_pkg::DEF_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: push_value [31:0], pop_count [35:32], zero fill [39:36]
   input  logic [39:0] req_tdata,
   // req_tuser: command [1:0]
   input  logic [1:0]  req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rsp_tdata: popped_value [31:0], fill_level [35:32], zero fill [39:36]
   output logic [39:0] rsp_tdata,
   // rsp_tuser: status [1:0]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready
);
   import cdq_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   logic [VALUE_W-1:0] out_value;
   logic [FILL_W-1:0]  out_fill;

   // sequencer
   cdq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .status   (status),
      .cmd      (cmd)
   );

   // store, pointers and response register
   cdq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_command (req_tuser),
      .in_value   (req_tdata[31:0]),
      .in_count   (req_tdata[35:32]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_value  (out_value),
      .out_status (rsp_tuser),
      .out_last   (rsp_tlast),
      .out_fill   (out_fill)
   );

   assign rsp_tdata = {4'b0000, out_fill, out_value};

endmodule

// ===== sim/circular_deque_checker.sv =====
module circular_deque_checker #(
   parameter int CAPACITY = cdq_pkg::DEF_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: push_value [31:0], pop_count [35:32], zero fill [39:36]
   input  logic [39:0] req_tdata,
   // req_tuser: command [1:0]
   input  logic [1:0]  req_tuser,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // rsp_tdata: popped_value [31:0], fill_level [35:32], zero fill [39:36]
   input  logic [39:0] rsp_tdata,
   // rsp_tuser: status [1:0]
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   output int          fail_count,
   output int          pending,
   output int          words_checked,
   output int          refused_pushes,
   output int          empty_pops
);
   import cdq_pkg::*;

   // one response word as the deque should give it
   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [STATUS_W-1:0] status;
      logic                last;
      logic [FILL_W-1:0]   fill;
   } deque_word_type;

   // shadow copy of the deque contents and pointers
   logic [VALUE_W-1:0] slots [CAPACITY];
   int front_pos;
   int rear_pos;
   int stored;

   deque_word_type due_words[$];
   int n_fail = 0;
   int n_words = 0;
   int n_full = 0;
   int n_empty = 0;

   // append a word, tagged with the fill level at this point
   task automatic queue_word(input logic [VALUE_W-1:0] value,
                             input logic [STATUS_W-1:0] status, input logic last);
      deque_word_type w;
      w.value = value;
      w.status = status;
      w.last = last;
      w.fill = stored[FILL_W-1:0];
      due_words.push_back(w);
   endtask

   // apply one command to the shadow deque and queue the words it gives
   task automatic advance_deque(input logic [CMD_W-1:0] cmd,
                                input logic [VALUE_W-1:0] value,
                                input logic [COUNT_W-1:0] count);
      int want;
      int take;
      if (cmd == CMD_PUSH_REAR || cmd == CMD_PUSH_FRONT) begin
         if (stored >= CAPACITY) begin
            n_full++;
            queue_word('0, ST_FULL, 1'b1);
         end else begin
            if (cmd == CMD_PUSH_REAR) begin
               rear_pos = (rear_pos + 1) % CAPACITY;
               slots[rear_pos] = value;
            end else begin
               front_pos = (front_pos == 0) ? CAPACITY - 1 : front_pos - 1;
               slots[front_pos] = value;
            end
            stored++;
            queue_word('0, ST_OK, 1'b1);
         end
      end else if (stored == 0) begin
         n_empty++;
         queue_word('0, ST_EMPTY, 1'b1);
      end else if (count == 0) begin
         // zero count leaves the deque alone
         queue_word('0, ST_OK, 1'b1);
      end else begin
         want = (count > MAX_RESULTS) ? MAX_RESULTS : int'(count);
         take = (want < stored) ? want : stored;
         for (int k = 0; k < take; k++) begin
            stored--;
            if (cmd == CMD_POP_FRONT) begin
               queue_word(slots[front_pos], ST_OK, k == take - 1);
               front_pos = (front_pos + 1) % CAPACITY;
            end else begin
               queue_word(slots[rear_pos], ST_OK, k == take - 1);
               rear_pos = (rear_pos == 0) ? CAPACITY - 1 : rear_pos - 1;
            end
         end
      end
   endtask

   // compare response words first, then predict from the request word
   always @(posedge clock) begin
      deque_word_type got;
      deque_word_type want;
      if (reset) begin
         front_pos = 0;
         rear_pos = CAPACITY - 1;
         stored = 0;
         due_words.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.value = rsp_tdata[VALUE_W-1:0];
            got.fill = rsp_tdata[VALUE_W+FILL_W-1:VALUE_W];
            got.status = rsp_tuser;
            got.last = rsp_tlast;
            n_words++;
            if (due_words.size() == 0) begin
               if (n_fail < 10)
                  $display("unexpected response word: value %h status %0d last %0b fill %0d",
                           got.value, got.status, got.last, got.fill);
               n_fail++;
            end else begin
               want = due_words.pop_front();
               if (got.value !== want.value || got.status !== want.status ||
                   got.last !== want.last || got.fill !== want.fill) begin
                  if (n_fail < 10) begin
                     $display("response word %0d mismatch", n_words);
                     $display("   expected value %h status %0d last %0b fill %0d",
                              want.value, want.status, want.last, want.fill);
                     $display("   actual   value %h status %0d last %0b fill %0d",
                              got.value, got.status, got.last, got.fill);
                  end
                  n_fail++;
               end
            end
         end
         if (req_tvalid && req_tready)
            advance_deque(req_tuser, req_tdata[VALUE_W-1:0],
                          req_tdata[VALUE_W+COUNT_W-1:VALUE_W]);
      end
      fail_count <= n_fail;
      pending <= due_words.size();
      words_checked <= n_words;
      refused_pushes <= n_full;
      empty_pops <= n_empty;
   end

endmodule

// ===== sim/circular_deque_tb.sv =====
module circular_deque_tb;
   import cdq_pkg::*;

   localparam int ITEMS = 150;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;

   // no idling on either side while set
   logic calm = 1'b0;

   int fail_count;
   int pending;
   int words_checked;
   int refused_pushes;
   int empty_pops;
   int idle_cycles = 0;
   int n_push = 0;
   int n_pop = 0;

   circular_deque u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   circular_deque_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .fail_count     (fail_count),
      .pending        (pending),
      .words_checked  (words_checked),
      .refused_pushes (refused_pushes),
      .empty_pops     (empty_pops)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // response side backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 12);
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("no word moved for %0d cycles", STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // present one request word and wait until it is taken
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                            input logic [COUNT_W-1:0] count);
      while (!calm && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {4'b0, count, value};
      if (cmd == CMD_PUSH_REAR || cmd == CMD_PUSH_FRONT)
         n_push++;
      else
         n_pop++;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   initial begin
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] count;
      bit                 filling;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // pops on an empty deque, with and without a count
      send_word(CMD_POP_FRONT, 32'h1234_5678, 4'd1);
      send_word(CMD_POP_REAR, 32'h0, 4'd0);
      // extreme values from both ends
      send_word(CMD_PUSH_REAR, 32'h7FFF_FFFF, 4'd0);
      send_word(CMD_PUSH_FRONT, 32'h8000_0000, 4'd15);
      send_word(CMD_PUSH_REAR, 32'h0000_0000, 4'd8);
      send_word(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 4'd1);
      // zero count on a non-empty deque
      send_word(CMD_POP_FRONT, 32'hFFFF_FFFF, 4'd0);
      // fill up, then try both pushes while full
      send_word(CMD_PUSH_REAR, 32'h5555_5555, 4'd3);
      send_word(CMD_PUSH_REAR, 32'hAAAA_AAAA, 4'd4);
      send_word(CMD_PUSH_FRONT, 32'h0000_0001, 4'd5);
      send_word(CMD_PUSH_FRONT, 32'hFFFF_FFFE, 4'd6);
      send_word(CMD_PUSH_REAR, 32'h0F0F_0F0F, 4'd7);
      send_word(CMD_PUSH_FRONT, 32'hF0F0_F0F0, 4'd9);
      // oversized count drains all eight
      send_word(CMD_POP_FRONT, 32'h0, 4'd15);
      // push three at the front, then pop from the rear
      send_word(CMD_PUSH_FRONT, 32'h0000_0011, 4'd0);
      send_word(CMD_PUSH_FRONT, 32'h0000_0022, 4'd0);
      send_word(CMD_PUSH_FRONT, 32'h0000_0033, 4'd0);
      send_word(CMD_POP_REAR, 32'h0, 4'd2);
      // short pop, then empty again
      send_word(CMD_POP_FRONT, 32'h0, 4'd9);
      send_word(CMD_POP_REAR, 32'h0, 4'd4);

      // random part: alternating fill and drain bursts
      for (int i = 0; i < ITEMS; i++) begin
         calm <= (i >= 80 && i < 120);
         filling = ((i / 16) % 2 == 0);
         if ($urandom_range(99) < (filling ? 75 : 25))
            cmd = $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
         else
            cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_REAR;
         case ($urandom_range(9))
            0: value = 32'h7FFF_FFFF;
            1: value = 32'h8000_0000;
            default: value = $urandom;
         endcase
         if ($urandom_range(9) == 0)
            count = COUNT_W'($urandom_range(15));
         else
            count = COUNT_W'($urandom_range(8, 1));
         send_word(cmd, value, count);
      end
      calm <= 1'b0;
      req_tvalid <= 1'b0;

      // drain outstanding words, then let any stray word show up
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d commands: %0d pushes and %0d pops, %0d response words checked",
               n_push + n_pop, n_push, n_pop, words_checked);
      $display("%0d pushes refused on a full deque, %0d pops on an empty one",
               refused_pushes, empty_pops);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d failures", fail_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/cdq_pkg.sv
src/cdq_datapath.sv
src/cdq_ctrl.sv
src/circular_deque.sv
sim/circular_deque_checker.sv
sim/circular_deque_tb.sv
